// ----- rtl/core/lfgg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// LED frame gradient generator package
// Transaction types and frame constants shared by the generator.
// ----------------------------------------------------------------------------
package lfgg_pkg;

    localparam int unsigned FRAME_LEN  = 12;
    localparam int unsigned BYTE_IDX_W = $clog2(FRAME_LEN);

    localparam logic [BYTE_IDX_W-1:0] IDX_BRIGHT = BYTE_IDX_W'(4);
    localparam logic [BYTE_IDX_W-1:0] IDX_BLUE   = BYTE_IDX_W'(5);
    localparam logic [BYTE_IDX_W-1:0] IDX_GREEN  = BYTE_IDX_W'(6);
    localparam logic [BYTE_IDX_W-1:0] IDX_RED    = BYTE_IDX_W'(7);
    localparam logic [BYTE_IDX_W-1:0] IDX_LAST   = BYTE_IDX_W'(FRAME_LEN - 1);

    localparam logic [7:0] START_BYTE  = 8'h00;
    localparam logic [7:0] END_BYTE    = 8'hFF;
    localparam logic [2:0] BRIGHT_MARK = 3'b111;
    localparam logic [7:0] FULL        = 8'hFF;

    // Wheel cursor codes: which component is rising
    localparam logic [1:0] CUR_RED   = 2'd0;
    localparam logic [1:0] CUR_GREEN = 2'd1;
    localparam logic [1:0] CUR_BLUE  = 2'd2;
    localparam logic [1:0] CUR_NONE  = 2'd3;

    localparam logic ACT_GIVEN    = 1'b0;
    localparam logic ACT_GRADIENT = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [4:0] level;
    } req_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/led_frame_gradient_generator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// LED frame gradient generator
// Emits one 12-byte APA102 frame per request, with an optional color wheel.
// ----------------------------------------------------------------------------
// Each request transaction yields twelve response transactions: four 0x00
// start bytes, 0xE0 | level, blue, green, red, then four 0xFF end bytes, with
// last_byte set on the twelfth. Action 1 sends the stored wheel color and
// steps the wheel when the request is taken. The frame byte counter emits one
// byte per cycle while the response side does not stall; the next request is
// accepted in the cycle the last byte of the current frame moves into the
// output register.
module led_frame_gradient_generator
    import lfgg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    logic                  busy_reg,   busy_next;
    logic [BYTE_IDX_W-1:0] idx_reg,    idx_next;
    logic [7:0]            red_reg,    red_next;
    logic [7:0]            green_reg,  green_next;
    logic [7:0]            blue_reg,   blue_next;
    logic [4:0]            level_reg,  level_next;
    logic [7:0]            wred_reg,   wred_next;
    logic [7:0]            wgreen_reg, wgreen_next;
    logic [7:0]            wblue_reg,  wblue_next;
    logic [1:0]            cursor_reg, cursor_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg,    rsp_next;

    logic       out_load;
    logic       req_take;
    logic [7:0] probe;
    logic [1:0] cursor_mv;
    logic [7:0] byte_sel;

    assign out_load  = busy_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !busy_reg || (out_load && (idx_reg == IDX_LAST));
    assign req_take  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Wheel step
    always_comb
    begin
        case (cursor_reg)
            CUR_GREEN: probe = wgreen_reg;
            CUR_BLUE:  probe = wblue_reg;
            default:   probe = wred_reg;
        endcase

        cursor_mv = cursor_reg;
        if (probe == FULL)
        begin
            case (cursor_reg)
                CUR_RED:   cursor_mv = CUR_GREEN;
                CUR_GREEN: cursor_mv = CUR_BLUE;
                CUR_BLUE:  cursor_mv = CUR_RED;
                default:   cursor_mv = CUR_GREEN;
            endcase
        end

        wred_next   = wred_reg;
        wgreen_next = wgreen_reg;
        wblue_next  = wblue_reg;
        cursor_next = cursor_reg;
        if (req_take && (req.action == ACT_GRADIENT))
        begin
            cursor_next = cursor_mv;
            case (cursor_mv)
                CUR_RED:
                begin
                    wred_next  = wred_reg + 8'd1;
                    wblue_next = wblue_reg - 8'd1;
                end
                CUR_GREEN:
                begin
                    wgreen_next = wgreen_reg + 8'd1;
                    wred_next   = wred_reg - 8'd1;
                end
                CUR_BLUE:
                begin
                    wblue_next  = wblue_reg + 8'd1;
                    wgreen_next = wgreen_reg - 8'd1;
                end
                default: ; // stuck cursor: no color change
            endcase
        end
    end

    // Frame byte select
    always_comb
    begin
        case (idx_reg)
            4'd0, 4'd1, 4'd2, 4'd3: byte_sel = START_BYTE;
            IDX_BRIGHT: byte_sel = {BRIGHT_MARK, level_reg};
            IDX_BLUE:   byte_sel = blue_reg;
            IDX_GREEN:  byte_sel = green_reg;
            IDX_RED:    byte_sel = red_reg;
            default:    byte_sel = END_BYTE;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        level_next     = level_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        if (out_load)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.frame_byte = byte_sel;
            rsp_next.last_byte  = (idx_reg == IDX_LAST);
            idx_next            = idx_reg + BYTE_IDX_W'(1);
            if (idx_reg == IDX_LAST)
                busy_next = 1'b0;
        end

        if (req_take)
        begin
            busy_next  = 1'b1;
            idx_next   = '0;
            level_next = req.level;
            if (req.action == ACT_GRADIENT)
            begin
                red_next   = wred_reg;
                green_next = wgreen_reg;
                blue_next  = wblue_reg;
            end
            else
            begin
                red_next   = req.red;
                green_next = req.green;
                blue_next  = req.blue;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            wred_reg      <= FULL;
            wgreen_reg    <= 8'd0;
            wblue_reg     <= 8'd0;
            cursor_reg    <= CUR_GREEN;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
            wred_reg      <= wred_next;
            wgreen_reg    <= wgreen_next;
            wblue_reg     <= wblue_next;
            cursor_reg    <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        level_reg <= level_next;
        rsp_reg   <= rsp_next;
    end

endmodule
`default_nettype wire

// ----- tb/tb_led_frame_gradient_generator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED frame gradient generator testbench
// Sends request transactions under random gaps and stalls, predicts each
// 12-byte frame and the color wheel, and checks every response in order.
// ----------------------------------------------------------------------------
module tb_led_frame_gradient_generator;
    import lfgg_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned LONG_HOLD   = 250;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    rsp_t        frame_bytes_due[$];
    rsp_t        due_byte;
    logic [7:0]  wheel_rgb [0:2];
    logic [1:0]  wheel_rising;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    int unsigned rsp_hold_len;
    bit          req_gaps_on;
    bit          rsp_stalls_on;

    led_frame_gradient_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One wheel step: move the cursor on once the rising component is full,
    // then raise it and lower the one before it.
    function void step_wheel();
        logic [1:0] k;
        logic [1:0] probe;
        logic [1:0] prev;
        k = wheel_rising;
        probe = (k == CUR_NONE) ? CUR_RED : k;
        if (wheel_rgb[probe] == FULL)
        begin
            case (k)
                CUR_RED:   k = CUR_GREEN;
                CUR_GREEN: k = CUR_BLUE;
                CUR_BLUE:  k = CUR_RED;
                default:   k = CUR_GREEN;
            endcase
        end
        if (k != CUR_NONE)
        begin
            prev = (k == CUR_RED) ? CUR_BLUE : k - 2'd1;
            wheel_rgb[prev] = wheel_rgb[prev] - 8'd1;
            wheel_rgb[k]    = wheel_rgb[k] + 8'd1;
        end
        wheel_rising = k;
    endfunction

    function void predict_frame(input req_t item);
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic [BYTE_IDX_W-1:0] idx;
        rsp_t                  fb;
        if (item.action == ACT_GRADIENT)
        begin
            red   = wheel_rgb[CUR_RED];
            green = wheel_rgb[CUR_GREEN];
            blue  = wheel_rgb[CUR_BLUE];
        end
        else
        begin
            red   = item.red;
            green = item.green;
            blue  = item.blue;
        end
        for (int unsigned n = 0; n < FRAME_LEN; n++)
        begin
            idx = BYTE_IDX_W'(n);
            case (idx)
                IDX_BRIGHT: fb.frame_byte = {BRIGHT_MARK, item.level};
                IDX_BLUE:   fb.frame_byte = blue;
                IDX_GREEN:  fb.frame_byte = green;
                IDX_RED:    fb.frame_byte = red;
                default:    fb.frame_byte = (idx < IDX_BRIGHT) ? START_BYTE : END_BYTE;
            endcase
            fb.last_byte = (idx == IDX_LAST);
            frame_bytes_due.push_back(fb);
        end
        if (item.action == ACT_GRADIENT)
            step_wheel();
    endfunction

    // Responses are checked before the request of the same edge is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $error("unexpected response: frame_byte %02h last_byte %0b",
                           rsp.frame_byte, rsp.last_byte);
                    mismatch_count++;
                end
                else
                begin
                    due_byte = frame_bytes_due.pop_front();
                    if (rsp.frame_byte !== due_byte.frame_byte)
                    begin
                        $error("frame_byte: expected %02h, actual %02h",
                               due_byte.frame_byte, rsp.frame_byte);
                        mismatch_count++;
                    end
                    if (rsp.last_byte !== due_byte.last_byte)
                    begin
                        $error("last_byte: expected %0b, actual %0b",
                               due_byte.last_byte, rsp.last_byte);
                        mismatch_count++;
                    end
                end
            end
            if (req_valid && req_ready)
                predict_frame(req);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tb_led_frame_gradient_generator: errors");
            $finish;
        end
        else
            quiet_cycles++;
    end

    // Response side: a random stall before each byte, or one long hold on request.
    initial
    begin
        int unsigned stall;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rsp_hold_len != 0)
            begin
                stall = rsp_hold_len;
                rsp_hold_len = 0;
            end
            else
                stall = rsp_stalls_on ? $urandom_range(0, 6) : 0;
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    // Returns at the edge that takes the transaction; valid stays high.
    task automatic send_request(input req_t item);
        int unsigned gap;
        gap = req_gaps_on ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic release_request();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    function automatic req_t make_request(input logic action, input logic [7:0] red,
                                          input logic [7:0] green, input logic [7:0] blue,
                                          input logic [4:0] level);
        req_t item;
        item.action = action;
        item.red    = red;
        item.green  = green;
        item.blue   = blue;
        item.level  = level;
        return item;
    endfunction

    function automatic req_t random_request(input int unsigned gradient_pct);
        return make_request(($urandom_range(0, 99) < gradient_pct) ? ACT_GRADIENT : ACT_GIVEN,
                            8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
    endfunction

    task automatic test_directed_frames();
        req_gaps_on   = 1'b0;
        rsp_stalls_on = 1'b0;
        send_request(make_request(ACT_GIVEN, 8'h00, 8'h00, 8'h00, 5'd0));
        send_request(make_request(ACT_GIVEN, 8'hFF, 8'hFF, 8'hFF, 5'd31));
        send_request(make_request(ACT_GIVEN, 8'hAA, 8'h55, 8'hAA, 5'b10101));
        send_request(make_request(ACT_GIVEN, 8'h55, 8'hAA, 8'h55, 5'b01010));
        send_request(make_request(ACT_GIVEN, 8'h01, 8'h80, 8'h7F, 5'd1));
        send_request(make_request(ACT_GIVEN, 8'h80, 8'h00, 8'hFF, 5'd16));
        // gradient: level still applies, color fields ignored
        send_request(make_request(ACT_GRADIENT, 8'h00, 8'h00, 8'h00, 5'd0));
        send_request(make_request(ACT_GRADIENT, 8'hFF, 8'hFF, 8'hFF, 5'd31));
        send_request(make_request(ACT_GRADIENT, 8'hAA, 8'h55, 8'hAA, 5'd16));
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
        send_request(make_request(ACT_GIVEN, 8'h12, 8'h34, 8'h56, 5'd31));
        send_request(make_request(ACT_GRADIENT, 8'h00, 8'hFF, 8'h00, 5'd7));
        send_request(make_request(ACT_GIVEN, 8'hFE, 8'h01, 8'hFE, 5'd30));
    endtask

    task automatic test_random_traffic(input int unsigned count);
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
        for (int unsigned n = 0; n < count; n++)
        begin
            // drop the idling now and then for a stretch
            if (n % 50 == 25)
            begin
                req_gaps_on   = 1'b0;
                rsp_stalls_on = 1'b0;
            end
            else if (n % 50 == 40)
            begin
                req_gaps_on   = 1'b1;
                rsp_stalls_on = 1'b1;
            end
            send_request(random_request(75));
        end
    endtask

    task automatic test_gradient_streaming(input int unsigned count);
        req_gaps_on   = 1'b0;
        rsp_stalls_on = 1'b0;
        for (int unsigned n = 0; n < count; n++)
            send_request(random_request(100));
    endtask

    task automatic test_response_hold();
        req_gaps_on   = 1'b0;
        rsp_stalls_on = 1'b1;
        rsp_hold_len  = LONG_HOLD;
        for (int unsigned n = 0; n < 12; n++)
            send_request(random_request(70));
    endtask

    task automatic test_drain_pause();
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
        for (int unsigned n = 0; n < 8; n++)
            send_request(random_request(70));
        release_request();
        while (frame_bytes_due.size() != 0) @(posedge clk);
        for (int unsigned n = 0; n < 8; n++)
            send_request(random_request(70));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        rsp_hold_len   = 0;
        req_gaps_on    = 1'b0;
        rsp_stalls_on  = 1'b0;
        wheel_rgb[CUR_RED]   = FULL;
        wheel_rgb[CUR_GREEN] = 8'd0;
        wheel_rgb[CUR_BLUE]  = 8'd0;
        wheel_rising         = CUR_GREEN;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_random_traffic(150);
        test_response_hold();
        test_gradient_streaming(60);
        test_drain_pause();
        test_random_traffic(160);

        release_request();
        while (frame_bytes_due.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_led_frame_gradient_generator: clean");
        else
            $display("tb_led_frame_gradient_generator: errors");
        $finish;
    end

endmodule
